/* hw/rtl/iefp_pkg.sv */
package iefp_pkg;

    localparam int OP_W        = 3;
    localparam int IDX_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int MP_W        = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_BYTES   = 7;
    localparam int SLOTS_W     = 5;
    localparam int PAYLOAD_CAP = 60;
    localparam int IN_W        = 16;

    // Input item opcodes; the remaining codes are ignored
    typedef enum logic [OP_W-1:0] {
        OP_KEY     = 3'd0,
        OP_BUTTON  = 3'd1,
        OP_ENCODER = 3'd2,
        OP_POT     = 3'd3,
        OP_SEND    = 3'd4
    } opcode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_CODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_CODE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_CODE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 3'd7;

    // Source of the next frame byte
    typedef enum logic [2:0] {
        SEL_MAGIC = 3'd0,
        SEL_TYPE  = 3'd1,
        SEL_SEQ   = 3'd2,
        SEL_LEN   = 3'd3,
        SEL_CODE  = 3'd4,
        SEL_INDEX = 3'd5,
        SEL_VALUE = 3'd6,
        SEL_END   = 3'd7
    } byte_sel_t;

    typedef struct packed {
        logic      upd;        // apply an update item
        logic      start;      // begin a frame: clear scan, latch slot count
        logic      count_step; // counting pass: tally one source, advance
        logic      scan_init;  // rewind for the emit pass
        logic      ptr_inc;    // advance the scan pointer
        logic      src_clr;    // clear the source under the pointer
        logic      seq_inc;    // advance the sequence counter
        logic      out_load;   // load the output byte register
        byte_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic mp_zero;
        logic ptr_end;
        logic count_full;
        logic pend;
        logic remain_zero;
        logic out_free;
    } stat_t;

endpackage

/* hw/rtl/iefp_ctrl.sv */
module iefp_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [iefp_pkg::OP_W-1:0]   in_opcode,
    input  iefp_pkg::stat_t             stat,
    output iefp_pkg::cmd_t              cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_COUNT = 11'b000_0000_0010,
        ST_MAGIC = 11'b000_0000_0100,
        ST_TYPE  = 11'b000_0000_1000,
        ST_SEQ   = 11'b000_0001_0000,
        ST_LEN   = 11'b000_0010_0000,
        ST_SCAN  = 11'b000_0100_0000,
        ST_CODE  = 11'b000_1000_0000,
        ST_IDX   = 11'b001_0000_0000,
        ST_VAL   = 11'b010_0000_0000,
        ST_TAIL  = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_opcode == iefp_pkg::OP_SEND) begin
                        // zero payload budget: drop the send entirely
                        if (!stat.mp_zero) begin
                            cmd.start  = 1'b1;
                            state_next = ST_COUNT;
                        end
                    end else begin
                        cmd.upd = 1'b1;
                    end
                end
            end
            ST_COUNT: begin
                cmd.count_step = 1'b1;
                if (stat.ptr_end || stat.count_full) begin
                    state_next = ST_MAGIC;
                end
            end
            ST_MAGIC: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = iefp_pkg::SEL_MAGIC;
                    state_next   = ST_TYPE;
                end
            end
            ST_TYPE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = iefp_pkg::SEL_TYPE;
                    state_next   = ST_SEQ;
                end
            end
            ST_SEQ: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = iefp_pkg::SEL_SEQ;
                    cmd.seq_inc  = 1'b1;
                    state_next   = ST_LEN;
                end
            end
            ST_LEN: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = iefp_pkg::SEL_LEN;
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.remain_zero) begin
                    state_next = ST_TAIL;
                end else if (stat.pend) begin
                    state_next = ST_CODE;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_CODE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = iefp_pkg::SEL_CODE;
                    state_next   = ST_IDX;
                end
            end
            ST_IDX: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = iefp_pkg::SEL_INDEX;
                    state_next   = ST_VAL;
                end
            end
            ST_VAL: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = iefp_pkg::SEL_VALUE;
                    cmd.src_clr  = 1'b1;
                    cmd.ptr_inc  = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_TAIL: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = iefp_pkg::SEL_END;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/iefp_dp.sv */
module iefp_dp #(
    parameter int KEYS     = 16,
    parameter int ENCODERS = 4,
    parameter int BUTTONS  = 32,
    parameter int POTS     = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  iefp_pkg::cmd_t                  cmd,
    output iefp_pkg::stat_t                 stat,
    input  logic [iefp_pkg::OP_W-1:0]       in_opcode,
    input  logic [iefp_pkg::IDX_W-1:0]      in_index,
    input  logic [iefp_pkg::BYTE_W-1:0]     in_value,
    input  logic                            cfg_we,
    input  logic [iefp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iefp_pkg::BYTE_W-1:0]     cfg_wdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [iefp_pkg::BYTE_W-1:0]     m_tdata,
    output logic                            m_tlast
);

    localparam int TOTAL    = KEYS + ENCODERS + BUTTONS + POTS;
    localparam int PW       = $clog2(TOTAL);
    localparam int ENC_BASE = KEYS;
    localparam int BTN_BASE = KEYS + ENCODERS;
    localparam int POT_BASE = KEYS + ENCODERS + BUTTONS;
    localparam int BW       = iefp_pkg::BYTE_W;
    localparam int SW       = iefp_pkg::SLOTS_W;

    // configuration
    logic [BW-1:0]             cfg_byte_reg [iefp_pkg::CFG_BYTES];
    logic [iefp_pkg::MP_W-1:0] payload_limit_reg;

    // pending input state
    logic [KEYS-1:0]        key_changed_reg, key_changed_next;
    logic [KEYS-1:0]        key_pressed_reg, key_pressed_next;
    logic [BUTTONS-1:0]     btn_changed_reg, btn_changed_next;
    logic [BUTTONS-1:0]     btn_pressed_reg, btn_pressed_next;
    logic signed [BW-1:0]   enc_delta_reg  [ENCODERS];
    logic signed [BW-1:0]   enc_delta_next [ENCODERS];
    logic signed [BW:0]     enc_sum        [ENCODERS];
    logic [POTS-1:0]        pot_changed_reg, pot_changed_next;
    logic [BW-1:0]          pot_value_reg  [POTS];
    logic [BW-1:0]          seq_reg;

    // scan counters
    logic [PW-1:0] ptr_reg;
    logic [SW-1:0] events_reg;
    logic [SW-1:0] remain_reg;
    logic [SW-1:0] slots_reg;

    // output byte register
    logic          out_valid_reg;
    logic [BW-1:0] out_data_reg;
    logic          out_last_reg;

    // flattened view of all sources in send order
    logic [TOTAL-1:0] pend_vec;
    logic [BW-1:0]    src_val  [TOTAL];
    logic [BW-1:0]    src_code [TOTAL];

    logic [iefp_pkg::MP_W-1:0] mp_eff;
    logic [iefp_pkg::MP_W-1:0] mp_less1;
    logic [11:0]               slots_prod;
    logic [BW-1:0]             len_byte;
    logic [BW-1:0]             byte_next;
    logic                      out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;

    // (payload limit - 1) / 3 as a reciprocal multiply, exact below 128
    assign mp_eff     = (payload_limit_reg > iefp_pkg::MP_W'(iefp_pkg::PAYLOAD_CAP)) ?
                        iefp_pkg::MP_W'(iefp_pkg::PAYLOAD_CAP) : payload_limit_reg;
    assign mp_less1   = mp_eff - iefp_pkg::MP_W'(1);
    assign slots_prod = 12'(mp_less1) * 12'd43;

    assign len_byte = BW'({events_reg, 1'b0}) + BW'(events_reg) + BW'(1);

    assign stat.mp_zero     = (payload_limit_reg == '0);
    assign stat.ptr_end     = (ptr_reg == PW'(TOTAL - 1));
    assign stat.count_full  = (events_reg == slots_reg);
    assign stat.pend        = pend_vec[ptr_reg];
    assign stat.remain_zero = (remain_reg == '0);
    assign stat.out_free    = out_free;

    always_comb begin
        for (int i = 0; i < KEYS; i++) begin
            pend_vec[i] = key_changed_reg[i];
            src_val[i]  = BW'(key_pressed_reg[i]);
            src_code[i] = cfg_byte_reg[iefp_pkg::CFG_KEY_CODE];
        end
        for (int i = 0; i < ENCODERS; i++) begin
            pend_vec[ENC_BASE+i] = (enc_delta_reg[i] != '0);
            src_val[ENC_BASE+i]  = enc_delta_reg[i];
            src_code[ENC_BASE+i] = cfg_byte_reg[iefp_pkg::CFG_ENC_CODE];
        end
        for (int i = 0; i < BUTTONS; i++) begin
            pend_vec[BTN_BASE+i] = btn_changed_reg[i];
            src_val[BTN_BASE+i]  = BW'(btn_pressed_reg[i]);
            src_code[BTN_BASE+i] = cfg_byte_reg[iefp_pkg::CFG_BTN_CODE];
        end
        for (int i = 0; i < POTS; i++) begin
            pend_vec[POT_BASE+i] = pot_changed_reg[i];
            src_val[POT_BASE+i]  = pot_value_reg[i];
            src_code[POT_BASE+i] = cfg_byte_reg[iefp_pkg::CFG_POT_CODE];
        end
    end

    // index byte is the position within the source's own group
    function automatic logic [BW-1:0] src_index(input logic [PW-1:0] p);
        logic [BW-1:0] pb;
        pb = BW'(p);
        if (pb < BW'(ENC_BASE)) begin
            return pb;
        end else if (pb < BW'(BTN_BASE)) begin
            return pb - BW'(ENC_BASE);
        end else if (pb < BW'(POT_BASE)) begin
            return pb - BW'(BTN_BASE);
        end
        return pb - BW'(POT_BASE);
    endfunction

    always_comb begin
        unique case (cmd.out_sel)
            iefp_pkg::SEL_MAGIC: byte_next = cfg_byte_reg[iefp_pkg::CFG_MAGIC];
            iefp_pkg::SEL_TYPE:  byte_next = cfg_byte_reg[iefp_pkg::CFG_FRAME_TYPE];
            iefp_pkg::SEL_SEQ:   byte_next = seq_reg;
            iefp_pkg::SEL_LEN:   byte_next = len_byte;
            iefp_pkg::SEL_CODE:  byte_next = src_code[ptr_reg];
            iefp_pkg::SEL_INDEX: byte_next = src_index(ptr_reg);
            iefp_pkg::SEL_VALUE: byte_next = src_val[ptr_reg];
            iefp_pkg::SEL_END:   byte_next = cfg_byte_reg[iefp_pkg::CFG_END_CODE];
            default:             byte_next = '0;
        endcase
    end

    // saturate encoder sums to -127..127
    always_comb begin
        for (int i = 0; i < ENCODERS; i++) begin
            enc_sum[i] = (BW+1)'(enc_delta_reg[i]) + (BW+1)'(signed'(in_value));
        end
    end

    always_comb begin
        key_changed_next = key_changed_reg;
        key_pressed_next = key_pressed_reg;
        btn_changed_next = btn_changed_reg;
        btn_pressed_next = btn_pressed_reg;
        pot_changed_next = pot_changed_reg;
        enc_delta_next   = enc_delta_reg;
        if (cmd.upd) begin
            unique case (in_opcode)
                iefp_pkg::OP_KEY: begin
                    for (int i = 0; i < KEYS; i++) begin
                        if (in_index == iefp_pkg::IDX_W'(i)) begin
                            key_changed_next[i] = 1'b1;
                            key_pressed_next[i] = in_value[0];
                        end
                    end
                end
                iefp_pkg::OP_BUTTON: begin
                    for (int i = 0; i < BUTTONS; i++) begin
                        if (in_index == iefp_pkg::IDX_W'(i)) begin
                            btn_changed_next[i] = 1'b1;
                            btn_pressed_next[i] = in_value[0];
                        end
                    end
                end
                iefp_pkg::OP_ENCODER: begin
                    for (int i = 0; i < ENCODERS; i++) begin
                        if (in_index == iefp_pkg::IDX_W'(i)) begin
                            if (enc_sum[i] > 9'sd127) begin
                                enc_delta_next[i] = 8'sd127;
                            end else if (enc_sum[i] < -9'sd127) begin
                                enc_delta_next[i] = -8'sd127;
                            end else begin
                                enc_delta_next[i] = enc_sum[i][BW-1:0];
                            end
                        end
                    end
                end
                iefp_pkg::OP_POT: begin
                    for (int i = 0; i < POTS; i++) begin
                        if (in_index == iefp_pkg::IDX_W'(i)) begin
                            pot_changed_next[i] = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.src_clr) begin
            for (int i = 0; i < KEYS; i++) begin
                if (ptr_reg == PW'(i)) key_changed_next[i] = 1'b0;
            end
            for (int i = 0; i < ENCODERS; i++) begin
                if (ptr_reg == PW'(ENC_BASE + i)) enc_delta_next[i] = '0;
            end
            for (int i = 0; i < BUTTONS; i++) begin
                if (ptr_reg == PW'(BTN_BASE + i)) btn_changed_next[i] = 1'b0;
            end
            for (int i = 0; i < POTS; i++) begin
                if (ptr_reg == PW'(POT_BASE + i)) pot_changed_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < iefp_pkg::CFG_BYTES; i++) begin
                cfg_byte_reg[i] <= '0;
            end
            payload_limit_reg <= iefp_pkg::MP_W'(iefp_pkg::PAYLOAD_CAP);
        end else if (cfg_we) begin
            if (cfg_index == iefp_pkg::CFG_PAYLOAD_LIMIT) begin
                payload_limit_reg <= cfg_wdata[iefp_pkg::MP_W-1:0];
            end else begin
                cfg_byte_reg[cfg_index] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_changed_reg <= '0;
            key_pressed_reg <= '0;
            btn_changed_reg <= '0;
            btn_pressed_reg <= '0;
            pot_changed_reg <= '0;
            for (int i = 0; i < ENCODERS; i++) begin
                enc_delta_reg[i] <= '0;
            end
        end else begin
            key_changed_reg <= key_changed_next;
            key_pressed_reg <= key_pressed_next;
            btn_changed_reg <= btn_changed_next;
            btn_pressed_reg <= btn_pressed_next;
            pot_changed_reg <= pot_changed_next;
            enc_delta_reg   <= enc_delta_next;
        end
    end

    // pot readings are only read once their changed flag is set
    always_ff @(posedge aclk) begin
        if (cmd.upd && in_opcode == iefp_pkg::OP_POT) begin
            for (int i = 0; i < POTS; i++) begin
                if (in_index == iefp_pkg::IDX_W'(i)) pot_value_reg[i] <= in_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg    <= '0;
            ptr_reg    <= '0;
            events_reg <= '0;
            remain_reg <= '0;
            slots_reg  <= '0;
        end else begin
            if (cmd.seq_inc) begin
                seq_reg <= seq_reg + BW'(1);
            end
            if (cmd.start) begin
                ptr_reg    <= '0;
                events_reg <= '0;
                slots_reg  <= slots_prod[11:7];
            end else if (cmd.count_step) begin
                ptr_reg <= ptr_reg + PW'(1);
                if (pend_vec[ptr_reg] && (events_reg != slots_reg)) begin
                    events_reg <= events_reg + SW'(1);
                end
            end else if (cmd.scan_init) begin
                ptr_reg    <= '0;
                remain_reg <= events_reg;
            end else begin
                if (cmd.ptr_inc) begin
                    ptr_reg <= ptr_reg + PW'(1);
                end
                if (cmd.src_clr) begin
                    remain_reg <= remain_reg - SW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= byte_next;
            out_last_reg <= (cmd.out_sel == iefp_pkg::SEL_END);
        end
    end

endmodule

/* hw/rtl/input_event_frame_packer_core.sv */
// Channel   Dir  Width  Contents
// s_axis    in   16     opcode, index, value: key/button/encoder/pot update or send
// m_axis    out  8+1    frame byte, tlast on the end marker
// cfg       in   3+8    register index, write data
//
// An update item is taken directly in the idle state. A send item runs a counting
// pass over the sources in send order, ending early once the payload is full,
// then emits one byte per cycle while the output is free, pausing while the
// shared scan pointer steps over skipped sources, before each event and before
// the end marker. The output byte register lets a new item in while the end
// byte waits. Reset is synchronous, active low, and clears all flags and deltas.
module input_event_frame_packer_core #(
    parameter int KEYS     = 16,
    parameter int ENCODERS = 4,
    parameter int BUTTONS  = 32,
    parameter int POTS     = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [iefp_pkg::IN_W-1:0]       s_tdata,  // opcode[2:0], index[7:3], value[15:8]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [iefp_pkg::BYTE_W-1:0]     m_tdata,  // frame_byte[7:0]
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [iefp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iefp_pkg::BYTE_W-1:0]     cfg_wdata
);

    logic [iefp_pkg::OP_W-1:0]   in_opcode;
    logic [iefp_pkg::IDX_W-1:0]  in_index;
    logic [iefp_pkg::BYTE_W-1:0] in_value;
    iefp_pkg::cmd_t              cmd;
    iefp_pkg::stat_t             stat;

    assign in_opcode = s_tdata[2:0];
    assign in_index  = s_tdata[7:3];
    assign in_value  = s_tdata[15:8];

    iefp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_opcode (in_opcode),
        .stat      (stat),
        .cmd       (cmd)
    );

    iefp_dp #(
        .KEYS     (KEYS),
        .ENCODERS (ENCODERS),
        .BUTTONS  (BUTTONS),
        .POTS     (POTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_opcode (in_opcode),
        .in_index  (in_index),
        .in_value  (in_value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
